>>> rtl/device_address_dedup_table_assert.svh
// assertion macros shared by the table checks
`ifndef DEVICE_ADDRESS_DEDUP_TABLE_ASSERT_SVH
`define DEVICE_ADDRESS_DEDUP_TABLE_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define DDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddt check failed");

// next-cycle implication
`define DDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddt check failed");

`endif

>>> rtl/ddt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddt_pkg;

  localparam int ADDR_W  = 48;
  localparam int KIND_W  = 2;
  localparam int STR_W   = 8;
  localparam int INDEX_W = 16;
  localparam int TOTAL_W = 7;

  // action codes
  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // one stored device
  typedef struct packed {
    logic [ADDR_W-1:0]       addr;
    logic [KIND_W-1:0]       kind;
    logic signed [STR_W-1:0] strength;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/ddt_store.sv
`timescale 1ns / 1ps
`default_nettype none
module ddt_store #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire ddt_pkg::entry_t  wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output ddt_pkg::entry_t       rd_data
);

  ddt_pkg::entry_t mem [DEPTH];
  ddt_pkg::entry_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> rtl/device_address_dedup_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Duplicate filter table for scanned radio devices. Issue a command by holding
// start high while busy is low; the command is taken at that edge. A discovery
// report (action 0) walks the stored entries from index 0, one entry per cycle
// through the table memory's single read port: a matching address and type has
// its strength refreshed, a new device is appended while room remains, and a
// new device with a full table is dropped. A report gives no result and keeps
// busy high until the walk stops at a match or at the last entry, or, on an
// empty table, until the append is done. A read (action 1) keeps busy high
// for one cycle and its result shows on the ports from the next edge after
// the command edge, for exactly one cycle, marked by out_strobe; no new command
// is taken while busy is high. The receiver cannot stall,
// so it must take every result in the cycle it is shown. Reads at or past the
// count return zero data with out_entry_valid low. The table memory needs no
// clearing pass: only entries below the count are ever looked at.
module device_address_dedup_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // command side
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_action,
  input  wire logic [ddt_pkg::ADDR_W-1:0]         in_dev_addr,
  input  wire logic [ddt_pkg::KIND_W-1:0]         in_addr_kind,
  input  wire logic signed [ddt_pkg::STR_W-1:0]   in_signal_strength,
  input  wire logic [ddt_pkg::INDEX_W-1:0]        in_read_index,
  // result side
  output logic                                    out_strobe,
  output logic                                    out_entry_valid,
  output logic [ddt_pkg::INDEX_W-1:0]             out_echo_index,
  output logic [ddt_pkg::ADDR_W-1:0]              out_addr,
  output logic [ddt_pkg::KIND_W-1:0]              out_kind,
  output logic signed [ddt_pkg::STR_W-1:0]        out_strength,
  output logic [ddt_pkg::TOTAL_W-1:0]             out_entry_total
);

  // index and count widths follow the table depth
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_RESP
  } state_t;

  state_t                        state_r;
  logic [CNT_W-1:0]              fill_r;
  logic [IDX_W-1:0]              idx_r;
  ddt_pkg::entry_t               key_r;
  logic                          rd_hit_r;
  logic [ddt_pkg::INDEX_W-1:0]   echo_r;

  logic                          out_strobe_r;
  logic                          out_valid_r;
  logic [ddt_pkg::INDEX_W-1:0]   out_echo_r;
  logic [ddt_pkg::ADDR_W-1:0]    out_addr_r;
  logic [ddt_pkg::KIND_W-1:0]    out_kind_r;
  logic signed [ddt_pkg::STR_W-1:0] out_strength_r;
  logic [ddt_pkg::TOTAL_W-1:0]   out_total_r;

  // memory port controls
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  ddt_pkg::entry_t               wr_data;
  ddt_pkg::entry_t               rd_data;

  logic                          accept;
  logic                          read_hit;
  logic                          table_full;
  logic                          scan_match;
  logic                          scan_last;
  ddt_pkg::entry_t               in_entry;

  assign accept     = start && !busy;
  assign busy       = (state_r != ST_IDLE);
  assign read_hit   = in_read_index < ddt_pkg::INDEX_W'(fill_r);
  assign table_full = (fill_r == CNT_W'(TABLE_DEPTH));

  // rd_data holds entry idx_r while scanning
  assign scan_match = (rd_data.addr == key_r.addr) && (rd_data.kind == key_r.kind);
  assign scan_last  = ((CNT_W'(idx_r) + 1'b1) == fill_r);

  assign in_entry.addr     = in_dev_addr;
  assign in_entry.kind     = in_addr_kind;
  assign in_entry.strength = in_signal_strength;

  // memory addressing for each state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = key_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ddt_pkg::ACT_READ) && read_hit) begin
          rd_en   = 1'b1;
          rd_addr = in_read_index[IDX_W-1:0];
        end else if (accept && (in_action == ddt_pkg::ACT_REPORT) && (fill_r != '0)) begin
          // start the walk at entry zero
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      ST_SCAN: begin
        if (scan_match) begin
          // known device, refresh strength in place
          wr_en   = 1'b1;
          wr_addr = idx_r;
        end else if (scan_last) begin
          // new device, append if there is room
          wr_en   = !table_full;
          wr_addr = fill_r[IDX_W-1:0];
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end
      ST_APPEND: begin
        // empty table, first entry
        wr_en   = 1'b1;
        wr_addr = fill_r[IDX_W-1:0];
      end
      ST_RESP: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // sequencer, count and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            key_r    <= in_entry;
            echo_r   <= in_read_index;
            rd_hit_r <= read_hit;
            idx_r    <= '0;
            if (in_action == ddt_pkg::ACT_READ) begin
              state_r <= ST_RESP;
            end else if (fill_r == '0) begin
              state_r <= ST_APPEND;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_match) begin
            state_r <= ST_IDLE;
          end else if (scan_last) begin
            if (!table_full) begin
              fill_r <= fill_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_APPEND: begin
          fill_r  <= fill_r + 1'b1;
          state_r <= ST_IDLE;
        end
        ST_RESP: begin
          // result goes out for one cycle, zeros when past the count
          out_strobe_r   <= 1'b1;
          out_valid_r    <= rd_hit_r;
          out_echo_r     <= echo_r;
          out_addr_r     <= rd_hit_r ? rd_data.addr : '0;
          out_kind_r     <= rd_hit_r ? rd_data.kind : '0;
          out_strength_r <= rd_hit_r ? rd_data.strength : '0;
          out_total_r    <= ddt_pkg::TOTAL_W'(fill_r);
          state_r        <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  ddt_store #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_strobe      = out_strobe_r;
  assign out_entry_valid = out_valid_r;
  assign out_echo_index  = out_echo_r;
  assign out_addr        = out_addr_r;
  assign out_kind        = out_kind_r;
  assign out_strength    = out_strength_r;
  assign out_entry_total = out_total_r;

endmodule
`default_nettype wire

>>> rtl/ddt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "device_address_dedup_table_assert.svh"
module ddt_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             out_strobe,
  input wire logic                             out_entry_valid,
  input wire logic [ddt_pkg::ADDR_W-1:0]       out_addr,
  input wire logic [ddt_pkg::KIND_W-1:0]       out_kind,
  input wire logic signed [ddt_pkg::STR_W-1:0] out_strength
);

  // every accepted transfer makes the sequencer busy in the following cycle
  `DDT_ASSERT_NXT(a_accept_busy, start && !busy, busy)

  // results are only shown once the sequencer is back to idle
  `DDT_ASSERT_IMP(a_strobe_idle, out_strobe, !busy)

  // a read holds the sequencer busy through its response state, so strobes never come back to back
  `DDT_ASSERT_NXT(a_strobe_single, out_strobe, !out_strobe)

  // a miss carries zero data
  `DDT_ASSERT_IMP(a_miss_zero, out_strobe && !out_entry_valid,
                  out_addr == '0 && out_kind == '0 && out_strength == '0)

endmodule

bind device_address_dedup_table ddt_checker u_ddt_checker (.*);
`default_nettype wire

>>> bench/tb_device_address_dedup_table.sv
`timescale 1ns / 1ps
module tb_device_address_dedup_table;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_POOL    = 96;
  localparam int RAND_PHASE  = 350;

  localparam int ADDR_W  = ddt_pkg::ADDR_W;
  localparam int KIND_W  = ddt_pkg::KIND_W;
  localparam int STR_W   = ddt_pkg::STR_W;
  localparam int INDEX_W = ddt_pkg::INDEX_W;
  localparam int TOTAL_W = ddt_pkg::TOTAL_W;

  // one command transfer as it goes onto the input ports
  typedef struct {
    logic                    action;
    logic [ADDR_W-1:0]       addr;
    logic [KIND_W-1:0]       kind;
    logic signed [STR_W-1:0] strength;
    logic [INDEX_W-1:0]      index;
  } dev_cmd_t;

  // one read result as it shows on the result ports
  typedef struct {
    logic                    valid;
    logic [INDEX_W-1:0]      index;
    logic [ADDR_W-1:0]       addr;
    logic [KIND_W-1:0]       kind;
    logic signed [STR_W-1:0] strength;
    logic [TOTAL_W-1:0]      total;
  } entry_read_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_action = ddt_pkg::ACT_REPORT;
  logic [ADDR_W-1:0]       in_dev_addr = '0;
  logic [KIND_W-1:0]       in_addr_kind = '0;
  logic signed [STR_W-1:0] in_signal_strength = '0;
  logic [INDEX_W-1:0]      in_read_index = '0;
  logic                    out_strobe;
  logic                    out_entry_valid;
  logic [INDEX_W-1:0]      out_echo_index;
  logic [ADDR_W-1:0]       out_addr;
  logic [KIND_W-1:0]       out_kind;
  logic signed [STR_W-1:0] out_strength;
  logic [TOTAL_W-1:0]      out_entry_total;

  device_address_dedup_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_dev_addr       (in_dev_addr),
    .in_addr_kind      (in_addr_kind),
    .in_signal_strength(in_signal_strength),
    .in_read_index     (in_read_index),
    .out_strobe        (out_strobe),
    .out_entry_valid   (out_entry_valid),
    .out_echo_index    (out_echo_index),
    .out_addr          (out_addr),
    .out_kind          (out_kind),
    .out_strength      (out_strength),
    .out_entry_total   (out_entry_total)
  );

  // commands waiting to be driven, filled by the stimulus process
  dev_cmd_t    scan_cmds[$];
  // read results the shadow table says must still come out, oldest first
  entry_read_t owed_reads[$];

  // shadow copy of the device table, updated at every accepted transfer
  ddt_pkg::entry_t known_devices[TABLE_DEPTH];
  int              known_count = 0;

  // key pool: random addresses, some sharing an address with another type
  logic [ADDR_W-1:0] pool_addr[KEY_POOL];
  logic [KIND_W-1:0] pool_kind[KEY_POOL];

  int sender_idle_pct = 0;
  int presented_total = 0;
  int accepted_total  = 0;
  int error_count     = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // single reset at the start, released on a falling edge
  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
  end

  // hard stop well past the slowest correct run
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // append one command to the pending queue
  function automatic void add_cmd(dev_cmd_t c);
    scan_cmds = {scan_cmds, c};
  endfunction

  // shadow table update for one accepted command; a read owes one result
  function automatic void apply_to_known_devices(dev_cmd_t c);
    entry_read_t r;
    int          hit;
    hit = -1;
    if (c.action == ddt_pkg::ACT_REPORT) begin
      // search from index 0, first match wins
      for (int i = 0; i < known_count; i++) begin
        if (hit < 0 && known_devices[i].kind == c.kind && known_devices[i].addr == c.addr)
          hit = i;
      end
      if (hit >= 0) begin
        known_devices[hit].strength = c.strength;
      end else if (known_count < TABLE_DEPTH) begin
        known_devices[known_count] = '{addr: c.addr, kind: c.kind, strength: c.strength};
        known_count++;
      end
      // a miss with a full table is dropped without trace
    end else begin
      r.index = c.index;
      r.total = known_count[TOTAL_W-1:0];
      if (int'(c.index) < known_count) begin
        r.valid    = 1'b1;
        r.addr     = known_devices[c.index].addr;
        r.kind     = known_devices[c.index].kind;
        r.strength = known_devices[c.index].strength;
      end else begin
        // at or past the count: zero data, index and count still reported
        r.valid    = 1'b0;
        r.addr     = '0;
        r.kind     = '0;
        r.strength = '0;
      end
      owed_reads = {owed_reads, r};
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // driver: new values go out on the falling edge; a presented command is
  // held until its transfer, then the next one follows or start drops
  always @(negedge clk) begin : drive_cmds
    dev_cmd_t nxt;
    if (rst_n && !(start && accepted_total != presented_total)) begin
      if (scan_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = scan_cmds.pop_front();
        in_action          <= nxt.action;
        in_dev_addr        <= nxt.addr;
        in_addr_kind       <= nxt.kind;
        in_signal_strength <= nxt.strength;
        in_read_index      <= nxt.index;
        start              <= 1'b1;
        presented_total    <= presented_total + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results are checked before the transfer of this edge is
  // applied, since a result always belongs to an earlier read
  always @(posedge clk) begin : watch_ports
    entry_read_t want;
    dev_cmd_t    seen;
    if (rst_n) begin
      if (out_strobe) begin
        if (owed_reads.size() == 0) begin
          $error("read result with no read outstanding");
          error_count++;
        end else begin
          want = owed_reads.pop_front();
          check_field("entry_valid", want.valid, out_entry_valid);
          check_field("echo_index", want.index, out_echo_index);
          check_field("out_addr", want.addr, out_addr);
          check_field("out_kind", want.kind, out_kind);
          check_field("out_strength", want.strength, out_strength);
          check_field("entry_total", want.total, out_entry_total);
        end
      end
      if (start && !busy) begin
        seen.action   = in_action;
        seen.addr     = in_dev_addr;
        seen.kind     = in_addr_kind;
        seen.strength = in_signal_strength;
        seen.index    = in_read_index;
        apply_to_known_devices(seen);
        accepted_total++;
      end
    end
  end

  function automatic dev_cmd_t make_report(logic [ADDR_W-1:0] a, logic [KIND_W-1:0] k,
                                           logic signed [STR_W-1:0] s);
    dev_cmd_t c;
    c.action   = ddt_pkg::ACT_REPORT;
    c.addr     = a;
    c.kind     = k;
    c.strength = s;
    c.index    = INDEX_W'($urandom);  // ignored by a report
    return c;
  endfunction

  function automatic dev_cmd_t make_read(logic [INDEX_W-1:0] idx);
    dev_cmd_t c;
    c.action   = ddt_pkg::ACT_READ;
    c.addr     = {16'($urandom), 32'($urandom)};  // ignored by a read
    c.kind     = KIND_W'($urandom);
    c.strength = STR_W'($urandom);
    c.index    = idx;
    return c;
  endfunction

  // wait until every queued command is taken and every owed result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (scan_cmds.size() != 0 || start || busy || owed_reads.size() != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int pick;
    int sel;
    for (int i = 0; i < KEY_POOL; i++) begin
      if (i % 4 == 3) begin
        // same address as the previous key, different type
        pool_addr[i] = pool_addr[i-1];
        pool_kind[i] = pool_kind[i-1] ^ KIND_W'($urandom_range(1, 3));
      end else begin
        pool_addr[i] = {16'($urandom), 32'($urandom)};
        pool_kind[i] = KIND_W'($urandom);
      end
    end

    // directed: empty table reads, field extremes, type as part of the key,
    // strength refresh on a hit, reads at and past the count
    sender_idle_pct = 21;
    add_cmd(make_read(16'd0));
    add_cmd(make_read(16'hFFFF));
    add_cmd(make_report(48'h0, 2'd0, -8'sd128));
    add_cmd(make_report(48'hFFFF_FFFF_FFFF, 2'd3, 8'sd127));
    add_cmd(make_report(48'hFFFF_FFFF_FFFF, 2'd0, 8'sd0));
    add_cmd(make_report(48'h0, 2'd0, 8'sd5));
    add_cmd(make_read(16'd0));
    add_cmd(make_read(16'd1));
    add_cmd(make_read(16'd2));
    add_cmd(make_read(16'd3));
    add_cmd(make_read(16'd64));
    add_cmd(make_report(48'h0, 2'd1, -8'sd1));
    add_cmd(make_report(48'h0, 2'd0, 8'sd127));
    add_cmd(make_report(48'h5555_5555_5555, 2'd2, -8'sd60));
    add_cmd(make_report(48'hAAAA_AAAA_AAAA, 2'd1, 8'sd42));
    add_cmd(make_read(16'd0));
    add_cmd(make_read(16'd3));
    add_cmd(make_read(16'd4));
    add_cmd(make_read(16'd5));
    add_cmd(make_read(16'h8000));
    // sender holds off here until every owed result has come back
    wait_drained();

    // random phases: sender idles rarely, often, then never; the key pool
    // is larger than the table so it fills and later misses get dropped
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 84 : 0;
      for (int n = 0; n < RAND_PHASE; n++) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          pick = $urandom_range(KEY_POOL - 1);
          add_cmd(make_report(pool_addr[pick], pool_kind[pick], STR_W'($urandom)));
        end else if (sel < 55) begin
          // unknown device, nearly always a miss
          add_cmd(make_report({16'($urandom), 32'($urandom)}, KIND_W'($urandom),
                              STR_W'($urandom)));
        end else if (sel < 91) begin
          add_cmd(make_read(INDEX_W'($urandom_range(0, TABLE_DEPTH + 6))));
        end else begin
          add_cmd(make_read(INDEX_W'($urandom)));
        end
      end
      wait_drained();
    end

    // late results or stray strobes still get caught here
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> device_address_dedup_table.f
+incdir+rtl
rtl/ddt_pkg.sv
rtl/ddt_store.sv
rtl/device_address_dedup_table.sv
rtl/ddt_checker.sv
bench/tb_device_address_dedup_table.sv
